@@ hw/rtl/esp_pkg.sv @@
// Shared constants, codes and types of the eased scale pulse animator.
`timescale 1ns / 1ps

package esp_pkg;

   // Default parameter values
   localparam int SCALE_FRAC_BITS_DEF = 12;
   localparam int TIME_BITS_DEF       = 16;

   // Progress is Q0.16
   localparam int PROG_BITS = 16;
   localparam logic [PROG_BITS:0] P_FULL = {1'b1, {PROG_BITS{1'b0}}};

   // Shared multiplier shape
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = PROG_BITS + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Action codes
   localparam int ACTION_W = 2;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TRIGGER = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTORE = 2'd2;

   // Register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SCALE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXIMUM_SCALE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_STEP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSITION_TICKS = 3'd4;

   localparam logic [CSR_DATA_W-1:0] RST_INITIAL_SCALE    = 16'd6144;
   localparam logic [CSR_DATA_W-1:0] RST_MAXIMUM_SCALE    = 16'd12288;
   localparam logic [CSR_DATA_W-1:0] RST_SCALE_STEP       = 16'd2048;
   localparam logic [CSR_DATA_W-1:0] RST_HOLD_TICKS       = 16'd30;
   localparam logic [CSR_DATA_W-1:0] RST_TRANSITION_TICKS = 16'd10;

   // Divider control and status
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ hw/rtl/esp_req_if.sv @@
// Request channel: one input word per handshake.
`timescale 1ns / 1ps

interface esp_req_if import esp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic                cursor_usable;
   logic                cursor_unchanged;

   modport source (output valid, action, cursor_usable, cursor_unchanged, input ready);
   modport sink   (input valid, action, cursor_usable, cursor_unchanged, output ready);
endinterface

@@ hw/rtl/esp_rsp_if.sv @@
// Response channel: one result word per handshake.
`timescale 1ns / 1ps

interface esp_rsp_if ();
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        effect_active;
   logic [15:0] current_scale_out;
   logic        finished;
   logic        aborted;

   modport source (output valid, accepted, effect_active, current_scale_out, finished,
                   aborted, input ready);
   modport sink   (input valid, accepted, effect_active, current_scale_out, finished,
                   aborted, output ready);
endinterface

@@ hw/rtl/eased_scale_pulse_animator.sv @@
// Top level of the eased scale pulse animator: sequencer, state, shared multiplier and progress divider.
`timescale 1ns / 1ps
//
//  channel  dir  handshake              word contents
//  req_ch   in   valid/ready            action, cursor_usable, cursor_unchanged
//  rsp_ch   out  valid/ready            accepted, effect_active, current_scale_out,
//                                       finished, aborted
//  csr_*    in   csr_we (no stall)      csr_index, csr_wdata
//
//  Trigger, restore, idle tick, unused action or abort: accept, then load the output word.
//  A running tick at full progress: multiply, write back, output.
//  Any other running tick: the 16-step progress divider, then three passes
//  through the one shared multiplier (x^2, x^3, span*ease), then write back and output.
//  Reset is synchronous; it restores the configuration and effect state.
//  A stalled rsp_ch holds its word; one new request is still taken and
//  worked on, and only its final output load waits for the slot to free.
//
module eased_scale_pulse_animator import esp_pkg::*; #(
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
   parameter int TIME_BITS       = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   esp_req_if.sink               req_ch,
   esp_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Scales need one bit more than the fraction so 1.0 fits at 16 fraction bits
   localparam int SW = (SCALE_FRAC_BITS + 1 > CSR_DATA_W) ? SCALE_FRAC_BITS + 1 : CSR_DATA_W;
   // Common width for comparing elapsed time against the transition length
   localparam int CW = (TIME_BITS > PROG_BITS) ? TIME_BITS : PROG_BITS;
   localparam logic [SW-1:0]        ONE  = {{(SW-1){1'b0}}, 1'b1} << SCALE_FRAC_BITS;
   localparam logic [TIME_BITS-1:0] TMAX = '1;
   localparam logic [MUL_P_W:0]     RND  = (MUL_P_W + 1)'(1) << (PROG_BITS - 1);

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_EASE = 3'd4;
   localparam logic [2:0] ST_MUL3 = 3'd5;
   localparam logic [2:0] ST_WB   = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   // Configuration
   logic [CSR_DATA_W-1:0] init_ff, max_ff, step_ff, hold_cfg_ff, trans_ff;

   // Effect state
   logic                 running_ff, running_in;
   logic [SW-1:0]        present_ff, present_in;
   logic [SW-1:0]        start_ff, start_in;
   logic [SW-1:0]        goal_ff, goal_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [15:0]          hold_ff, hold_in;

   // Sequencer and per-word scratch
   logic [2:0]           state_ff, state_in;
   logic                 acc_ff, acc_in;
   logic                 fin_ff, fin_in;
   logic                 abt_ff, abt_in;
   logic                 full_ff, full_in;
   logic                 low_ff, low_in;
   logic [PROG_BITS-1:0] x_ff, x_in;
   logic [PROG_BITS:0]   e_ff, e_in;
   logic [MUL_P_W-1:0]   mul_ff;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_acc_ff, out_acc_in;
   logic                 out_act_ff, out_act_in;
   logic [15:0]          out_scale_ff, out_scale_in;
   logic                 out_fin_ff, out_fin_in;
   logic                 out_abt_ff, out_abt_in;

   // Divider hookup
   div_ctl_type          div_ctl;
   div_sts_type          div_sts;
   logic [PROG_BITS-1:0] div_dividend;
   logic [PROG_BITS-1:0] div_quo;

   // Combinational helpers
   logic                 req_fire;
   logic [SW-1:0]        mx;
   logic [SW-1:0]        init_ext;
   logic [TIME_BITS-1:0] el_n;
   logic [15:0]          hold_n;
   logic [CW-1:0]        el_ext;
   logic                 up;
   logic [SW-1:0]        span;
   logic [MUL_P_W:0]     rnd_sum;
   logic [SW-1:0]        d;
   logic [PROG_BITS:0]   t;

   function automatic logic [SW-1:0] clamp_goal(input logic [SW:0] tgt, input logic [SW-1:0] lim);
      logic [SW:0] r;
      r = tgt;
      if (r > {1'b0, lim}) r = {1'b0, lim};
      if (r < {1'b0, ONE}) r = {1'b0, ONE};
      return r[SW-1:0];
   endfunction

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // A maximum below 1.0 acts as 1.0
   assign mx       = (SW'(max_ff) < ONE) ? ONE : SW'(max_ff);
   assign init_ext = SW'(init_ff);
   assign up       = goal_ff >= start_ff;
   assign span     = up ? goal_ff - start_ff : start_ff - goal_ff;
   assign rnd_sum  = {1'b0, mul_ff} + RND;
   assign d        = rnd_sum[PROG_BITS +: SW];
   // 4*x^3 >> 32 with x <= 0.5
   assign t        = mul_ff[30 +: PROG_BITS + 1];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= RST_INITIAL_SCALE;
         max_ff      <= RST_MAXIMUM_SCALE;
         step_ff     <= RST_SCALE_STEP;
         hold_cfg_ff <= RST_HOLD_TICKS;
         trans_ff    <= RST_TRANSITION_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_SCALE:    init_ff     <= csr_wdata;
            CSR_MAXIMUM_SCALE:    max_ff      <= csr_wdata;
            CSR_SCALE_STEP:       step_ff     <= csr_wdata;
            CSR_HOLD_TICKS:       hold_cfg_ff <= csr_wdata;
            CSR_TRANSITION_TICKS: trans_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      running_in   = running_ff;
      present_in   = present_ff;
      start_in     = start_ff;
      goal_in      = goal_ff;
      elapsed_in   = elapsed_ff;
      hold_in      = hold_ff;
      state_in     = state_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      abt_in       = abt_ff;
      full_in      = full_ff;
      low_in       = low_ff;
      x_in         = x_ff;
      e_in         = e_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_ctl      = '0;
      el_n         = elapsed_ff;
      hold_n       = hold_ff;
      el_ext       = CW'(elapsed_ff);
      div_dividend = el_ext[PROG_BITS-1:0];
      rsp_valid_in = rsp_valid_ff;
      out_acc_in   = out_acc_ff;
      out_act_in   = out_act_ff;
      out_scale_in = out_scale_ff;
      out_fin_in   = out_fin_ff;
      out_abt_in   = out_abt_ff;

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               acc_in   = 1'b0;
               fin_in   = 1'b0;
               abt_in   = 1'b0;
               state_in = ST_FIN;
               case (req_ch.action)
                  ACT_TRIGGER: begin
                     if (!running_ff) begin
                        if (req_ch.cursor_usable) begin
                           running_in = 1'b1;
                           present_in = ONE;
                           start_in   = ONE;
                           goal_in    = clamp_goal({1'b0, (init_ext < mx) ? init_ext : mx}, mx);
                           elapsed_in = '0;
                           hold_in    = hold_cfg_ff;
                           acc_in     = 1'b1;
                        end
                     end else begin
                        // repeated trigger: restart from where we are
                        start_in   = present_ff;
                        goal_in    = clamp_goal({1'b0, goal_ff} + (SW + 1)'(step_ff), mx);
                        elapsed_in = '0;
                        hold_in    = hold_cfg_ff;
                        acc_in     = 1'b1;
                     end
                  end
                  ACT_RESTORE: begin
                     running_in = 1'b0;
                     present_in = ONE;
                     start_in   = ONE;
                     goal_in    = ONE;
                     elapsed_in = '0;
                     hold_in    = '0;
                  end
                  ACT_TICK: begin
                     if (running_ff) begin
                        if (!req_ch.cursor_unchanged) begin
                           running_in = 1'b0;
                           present_in = ONE;
                           start_in   = ONE;
                           goal_in    = ONE;
                           elapsed_in = '0;
                           hold_in    = '0;
                           abt_in     = 1'b1;
                        end else begin
                           el_n   = (elapsed_ff != TMAX) ? elapsed_ff + TIME_BITS'(1) : elapsed_ff;
                           hold_n = (hold_ff != 16'd0) ? hold_ff - 16'd1 : 16'd0;
                           // hold over: ease back toward 1.0
                           if (hold_n == 16'd0 && goal_ff != ONE) begin
                              start_in = present_ff;
                              goal_in  = ONE;
                              el_n     = '0;
                           end
                           elapsed_in   = el_n;
                           hold_in      = hold_n;
                           el_ext       = CW'(el_n);
                           div_dividend = el_ext[PROG_BITS-1:0];
                           full_in      = (trans_ff == '0) || (el_ext >= CW'(trans_ff));
                           if (full_in) begin
                              e_in     = P_FULL;
                              state_in = ST_MUL3;
                           end else begin
                              div_ctl.start = 1'b1;
                              state_in      = ST_DIV;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               // fold the upper half: x = 1 - p there
               low_in   = !div_quo[PROG_BITS-1];
               x_in     = div_quo[PROG_BITS-1] ? PROG_BITS'(0) - div_quo : div_quo;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            mul_a    = MUL_A_W'(x_ff);
            mul_b    = MUL_B_W'(x_ff);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a    = mul_ff[MUL_A_W-1:0];
            mul_b    = MUL_B_W'(x_ff);
            state_in = ST_EASE;
         end
         ST_EASE: begin
            e_in     = low_ff ? t : P_FULL - t;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            mul_a    = MUL_A_W'(span);
            mul_b    = e_ff;
            state_in = ST_WB;
         end
         ST_WB: begin
            present_in = up ? start_ff + d : start_ff - d;
            if (full_ff && goal_ff == ONE) begin
               running_in = 1'b0;
               present_in = ONE;
               start_in   = ONE;
               goal_in    = ONE;
               elapsed_in = '0;
               hold_in    = '0;
               fin_in     = 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_acc_in   = acc_ff;
               out_act_in   = running_ff;
               out_scale_in = present_ff[15:0];
               out_fin_in   = fin_ff;
               out_abt_in   = abt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
         present_ff   <= ONE;
         start_ff     <= ONE;
         goal_ff      <= ONE;
         elapsed_ff   <= '0;
         hold_ff      <= '0;
         acc_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         abt_ff       <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
         present_ff   <= present_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         elapsed_ff   <= elapsed_in;
         hold_ff      <= hold_in;
         acc_ff       <= acc_in;
         fin_ff       <= fin_in;
         abt_ff       <= abt_in;
         full_ff      <= full_in;
      end
      low_ff       <= low_in;
      x_ff         <= x_in;
      e_ff         <= e_in;
      mul_ff       <= mul_a * mul_b;
      out_acc_ff   <= out_acc_in;
      out_act_ff   <= out_act_in;
      out_scale_ff <= out_scale_in;
      out_fin_ff   <= out_fin_in;
      out_abt_ff   <= out_abt_in;
   end

   esp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (trans_ff),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.accepted          = out_acc_ff;
   assign rsp_ch.effect_active     = out_act_ff;
   assign rsp_ch.current_scale_out = out_scale_ff;
   assign rsp_ch.finished          = out_fin_ff;
   assign rsp_ch.aborted           = out_abt_ff;

   // Divider only reports back while the sequencer waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV)
      else $error("divider done outside ST_DIV");

   // Write back always follows the final multiply
   a_wb_after_mul3: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WB |-> $past(state_ff) == ST_MUL3)
      else $error("write back without span multiply");

   // At most one status flag per word, and a finished effect is not active
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $onehot0({rsp_ch.accepted, rsp_ch.finished, rsp_ch.aborted})
                       && !(rsp_ch.finished && rsp_ch.effect_active))
      else $error("inconsistent response flags");

   // Idle effect always sits at 1.0
   a_idle_at_one: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> present_ff == ONE && goal_ff == ONE)
      else $error("idle effect away from 1.0");

endmodule

@@ hw/rtl/esp_div.sv @@
// Radix-2 restoring divider for the Q0.16 progress fraction.
`timescale 1ns / 1ps

module esp_div import esp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctl_type          ctl,
   input  logic [PROG_BITS-1:0] dividend,
   input  logic [PROG_BITS-1:0] divisor,
   output div_sts_type          sts,
   output logic [PROG_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(PROG_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROG_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PROG_BITS-1:0] rem_ff, rem_in;
   logic [PROG_BITS-1:0] dsr_ff, dsr_in;
   logic [PROG_BITS-1:0] quo_ff, quo_in;

   logic [PROG_BITS:0]   shifted;
   logic                 ge;

   // dividend < divisor, so the remainder always fits PROG_BITS
   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dsr_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? PROG_BITS'(shifted - {1'b0, dsr_ff}) : PROG_BITS'(shifted);
         quo_in = {quo_ff[PROG_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule
